// File: rtl/scccu_pkg.sv
// package for the sound chip channel control unit
// command codes, address map, frame divider defaults and stream types; no dependencies
`timescale 1ns / 1ps

package scccu_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam int ENVELOPE_TICKS_DEF = 174;
   localparam int SWEEP_TICKS_DEF    = 87;
   localparam int LENGTH_TICKS_DEF   = 43;

   localparam logic [15:0] WIN_LO      = 16'hff10;
   localparam logic [15:0] WIN_HI      = 16'hff3f;
   localparam logic [15:0] STATUS_ADDR = 16'hff26;

   // register offsets inside the window
   localparam logic [5:0] R_SWEEP   = 6'h00;
   localparam logic [5:0] R_LEN0    = 6'h01;
   localparam logic [5:0] R_ENV0    = 6'h02;
   localparam logic [5:0] R_FLO0    = 6'h03;
   localparam logic [5:0] R_FHI0    = 6'h04;
   localparam logic [5:0] R_LEN1    = 6'h06;
   localparam logic [5:0] R_ENV1    = 6'h07;
   localparam logic [5:0] R_FLO1    = 6'h08;
   localparam logic [5:0] R_FHI1    = 6'h09;
   localparam logic [5:0] R_WDAC    = 6'h0a;
   localparam logic [5:0] R_LEN2    = 6'h0b;
   localparam logic [5:0] R_FLO2    = 6'h0d;
   localparam logic [5:0] R_FHI2    = 6'h0e;
   localparam logic [5:0] R_LEN3    = 6'h10;
   localparam logic [5:0] R_ENV3    = 6'h11;
   localparam logic [5:0] R_CTRL3   = 6'h13;
   localparam logic [5:0] R_MASTER  = 6'h16;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [3:0]  channels_on;
      logic [3:0]  square1_volume;
      logic [3:0]  square2_volume;
      logic [3:0]  noise_volume;
      logic [10:0] square1_frequency;
   } result_type;

   // frame strobes from the divider to the channel core
   typedef struct packed {
      logic env;
      logic sweep;
      logic len;
   } strobe_type;

endpackage

// File: rtl/scccu_frame_divider.sv
// frame divider: three tick counters that strobe envelope, sweep and length steps
// depends on scccu_pkg
`timescale 1ns / 1ps

module scccu_frame_divider #(
   parameter int ENVELOPE_TICKS = scccu_pkg::ENVELOPE_TICKS_DEF,
   parameter int SWEEP_TICKS    = scccu_pkg::SWEEP_TICKS_DEF,
   parameter int LENGTH_TICKS   = scccu_pkg::LENGTH_TICKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick,
   output scccu_pkg::strobe_type  strobe
);

   logic [7:0] env_ff, env_in, swp_ff, swp_in, len_ff, len_in;

   always_comb begin
      strobe.env   = tick && ({1'b0, env_ff} + 9'd1 >= 9'(ENVELOPE_TICKS));
      strobe.sweep = tick && ({1'b0, swp_ff} + 9'd1 >= 9'(SWEEP_TICKS));
      strobe.len   = tick && ({1'b0, len_ff} + 9'd1 >= 9'(LENGTH_TICKS));
      env_in = env_ff;
      swp_in = swp_ff;
      len_in = len_ff;
      if (tick) begin
         env_in = strobe.env   ? 8'd0 : env_ff + 8'd1;
         swp_in = strobe.sweep ? 8'd0 : swp_ff + 8'd1;
         len_in = strobe.len   ? 8'd0 : len_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= '0;
         swp_ff <= '0;
         len_ff <= '0;
      end else begin
         env_ff <= env_in;
         swp_ff <= swp_in;
         len_ff <= len_in;
      end
   end

endmodule

// File: rtl/scccu_channel_core.sv
// channel core: register file, enables, envelopes, sweep and length counters
// depends on scccu_pkg; steps come from scccu_frame_divider
`timescale 1ns / 1ps

module scccu_channel_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid,
   input  scccu_pkg::cmd_type     cmd,
   input  logic [15:0]            bus_address,
   input  logic [7:0]             write_data,
   input  scccu_pkg::strobe_type  strobe,
   output logic                   tick,
   output scccu_pkg::result_type  result,
   output logic [7:0]             mem_data
);

   logic [7:0]  regs_ff [48];
   logic [47:0] vld_ff;
   logic [7:0]  mem_q_ff;
   logic        mem_sel_ff;
   logic [3:0]  en_ff, en_in;
   logic        master_ff, master_in;
   logic        wdac_ff, wdac_in;
   logic [3:0]  es_ff [3], es_in [3];
   logic        er_ff [3], er_in [3];
   logic [2:0]  ep_ff [3], ep_in [3];
   logic [2:0]  ec_ff [3], ec_in [3];
   logic [3:0]  vol_ff [3], vol_in [3];
   logic [8:0]  lc_ff [4], lc_in [4];
   logic        la_ff [4], la_in [4];
   logic [10:0] fc_ff [3], fc_in [3];
   logic [2:0]  sp_ff, sp_in, ss_ff, ss_in, sc_ff, sc_in;
   logic        sd_ff, sd_in;
   logic [10:0] sh_ff, sh_in;

   logic        in_win, wr, rd_mem;
   logic [15:0] offs16;
   logic [5:0]  offs;
   logic [2:0]  ec_dec;
   logic [2:0]  sc_dec;
   logic [10:0] delta;
   logic [11:0] sum;
   logic [8:0]  lim, lc_inc;
   logic [7:0]  rd;

   assign in_win = (bus_address >= scccu_pkg::WIN_LO) && (bus_address <= scccu_pkg::WIN_HI);
   assign offs16 = bus_address - scccu_pkg::WIN_LO;
   assign offs   = offs16[5:0];
   assign wr     = valid && cmd == scccu_pkg::CMD_WRITE && in_win;
   assign tick   = valid && cmd == scccu_pkg::CMD_TICK && master_ff;
   assign rd_mem = valid && cmd == scccu_pkg::CMD_READ && in_win &&
                   bus_address != scccu_pkg::STATUS_ADDR;

   always_comb begin
      en_in = en_ff; master_in = master_ff; wdac_in = wdac_ff;
      es_in = es_ff; er_in = er_ff; ep_in = ep_ff; ec_in = ec_ff; vol_in = vol_ff;
      lc_in = lc_ff; la_in = la_ff; fc_in = fc_ff;
      sp_in = sp_ff; sd_in = sd_ff; ss_in = ss_ff; sc_in = sc_ff; sh_in = sh_ff;
      delta = sh_ff >> ss_ff;
      sum = '0; ec_dec = '0; sc_dec = '0; lim = '0; lc_inc = '0;
      if (wr) begin
         unique case (offs)
            scccu_pkg::R_SWEEP: begin
               sp_in = write_data[6:4]; sd_in = write_data[3]; ss_in = write_data[2:0];
            end
            scccu_pkg::R_LEN0: lc_in[0] = {3'd0, write_data[5:0]};
            scccu_pkg::R_LEN1: lc_in[1] = {3'd0, write_data[5:0]};
            scccu_pkg::R_LEN2: lc_in[2] = {1'b0, write_data};
            scccu_pkg::R_LEN3: lc_in[3] = {3'd0, write_data[5:0]};
            scccu_pkg::R_ENV0, scccu_pkg::R_ENV1, scccu_pkg::R_ENV3: begin
               for (int e = 0; e < 3; e++) begin
                  if ((e == 0 && offs == scccu_pkg::R_ENV0) ||
                      (e == 1 && offs == scccu_pkg::R_ENV1) ||
                      (e == 2 && offs == scccu_pkg::R_ENV3)) begin
                     es_in[e] = write_data[7:4];
                     er_in[e] = write_data[3];
                     ep_in[e] = write_data[2:0];
                     if (write_data[7:3] == 5'd0) en_in[(e == 2) ? 3 : e] = 1'b0;
                  end
               end
            end
            scccu_pkg::R_FLO0: fc_in[0][7:0] = write_data;
            scccu_pkg::R_FLO1: fc_in[1][7:0] = write_data;
            scccu_pkg::R_FLO2: fc_in[2][7:0] = write_data;
            scccu_pkg::R_FHI0: begin
               fc_in[0][10:8] = write_data[2:0]; la_in[0] = write_data[6];
               if (write_data[7]) begin
                  // dac is on when envelope bits 7..3 are not all zero
                  if ({es_ff[0], er_ff[0]} != 5'd0) en_in[0] = 1'b1;
                  vol_in[0] = es_ff[0]; ec_in[0] = ep_ff[0];
                  sh_in = {write_data[2:0], fc_ff[0][7:0]};
                  sc_in = sp_ff;
                  if (lc_ff[0] >= 9'd64) lc_in[0] = '0;
               end
            end
            scccu_pkg::R_FHI1: begin
               fc_in[1][10:8] = write_data[2:0]; la_in[1] = write_data[6];
               if (write_data[7]) begin
                  if ({es_ff[1], er_ff[1]} != 5'd0) en_in[1] = 1'b1;
                  vol_in[1] = es_ff[1]; ec_in[1] = ep_ff[1];
                  if (lc_ff[1] >= 9'd64) lc_in[1] = '0;
               end
            end
            scccu_pkg::R_WDAC: begin
               wdac_in = write_data[7];
               if (!write_data[7]) en_in[2] = 1'b0;
            end
            scccu_pkg::R_FHI2: begin
               fc_in[2][10:8] = write_data[2:0]; la_in[2] = write_data[6];
               if (write_data[7]) begin
                  if (wdac_ff) en_in[2] = 1'b1;
                  if (lc_ff[2] >= 9'd256) lc_in[2] = '0;
               end
            end
            scccu_pkg::R_CTRL3: begin
               la_in[3] = write_data[6];
               if (write_data[7]) begin
                  if ({es_ff[2], er_ff[2]} != 5'd0) en_in[3] = 1'b1;
                  vol_in[2] = es_ff[2]; ec_in[2] = ep_ff[2];
                  if (lc_ff[3] >= 9'd64) lc_in[3] = '0;
               end
            end
            scccu_pkg::R_MASTER: begin
               master_in = write_data[7];
               if (!write_data[7]) en_in = '0;
            end
            default: ;
         endcase
      end
      // frame steps: envelope, then sweep, then length, as on the chip
      if (strobe.env) begin
         for (int e = 0; e < 3; e++) begin
            if (ep_ff[e] != 3'd0) begin
               ec_dec = (ec_ff[e] != 3'd0) ? ec_ff[e] - 3'd1 : 3'd0;
               ec_in[e] = ec_dec;
               if (ec_dec == 3'd0) begin
                  ec_in[e] = ep_ff[e];
                  if (er_ff[e]) begin
                     if (vol_ff[e] != 4'd15) vol_in[e] = vol_ff[e] + 4'd1;
                  end else if (vol_ff[e] != 4'd0) vol_in[e] = vol_ff[e] - 4'd1;
               end
            end
         end
      end
      if (strobe.sweep && sp_ff != 3'd0) begin
         sc_dec = (sc_ff != 3'd0) ? sc_ff - 3'd1 : 3'd0;
         sc_in = sc_dec;
         if (sc_dec == 3'd0) begin
            sc_in = sp_ff;
            if (ss_ff != 3'd0) begin
               sum = sd_ff ? {1'b0, sh_ff} - {1'b0, delta} : {1'b0, sh_ff} + {1'b0, delta};
               if (!sd_ff && sum[11]) en_in[0] = 1'b0;
               else begin
                  sh_in = sum[10:0];
                  fc_in[0] = sum[10:0];
               end
            end
         end
      end
      if (strobe.len) begin
         for (int c = 0; c < 4; c++) begin
            lim = (c == 2) ? 9'd256 : 9'd64;
            if (la_ff[c]) begin
               lc_inc = (lc_ff[c] < lim) ? lc_ff[c] + 9'd1 : lc_ff[c];
               lc_in[c] = lc_inc;
               if (lc_inc >= lim) en_in[c] = 1'b0;
            end
         end
      end
   end

   // register file bytes come through mem_data, registered when the request is taken
   always_comb begin
      rd = 8'd0;
      if (valid && cmd == scccu_pkg::CMD_READ) begin
         if (!in_win) rd = 8'hff;
         else if (bus_address == scccu_pkg::STATUS_ADDR) rd = {master_ff, 3'b111, en_ff};
      end
      result.read_data         = rd;
      result.channels_on       = en_in;
      result.square1_volume    = vol_in[0];
      result.square2_volume    = vol_in[1];
      result.noise_volume      = vol_in[2];
      result.square1_frequency = fc_in[0];
   end

   always_ff @(posedge clock) begin
      if (wr) regs_ff[offs] <= write_data;
   end

   always_ff @(posedge clock) begin
      if (valid) mem_q_ff <= regs_ff[offs];
   end

   // written flags make bytes read as zero until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         mem_sel_ff <= 1'b0;
      end else begin
         if (wr) vld_ff[offs] <= 1'b1;
         if (valid) mem_sel_ff <= rd_mem && vld_ff[offs];
      end
   end

   assign mem_data = mem_sel_ff ? mem_q_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= '0; master_ff <= 1'b0; wdac_ff <= 1'b0;
         for (int e = 0; e < 3; e++) begin
            es_ff[e] <= '0; er_ff[e] <= 1'b0; ep_ff[e] <= '0; ec_ff[e] <= '0;
            vol_ff[e] <= '0; fc_ff[e] <= '0;
         end
         for (int c = 0; c < 4; c++) begin
            lc_ff[c] <= '0; la_ff[c] <= 1'b0;
         end
         sp_ff <= '0; sd_ff <= 1'b0; ss_ff <= '0; sc_ff <= '0; sh_ff <= '0;
      end else begin
         en_ff <= en_in; master_ff <= master_in; wdac_ff <= wdac_in;
         es_ff <= es_in; er_ff <= er_in; ep_ff <= ep_in; ec_ff <= ec_in; vol_ff <= vol_in;
         lc_ff <= lc_in; la_ff <= la_in; fc_ff <= fc_in;
         sp_ff <= sp_in; sd_ff <= sd_in; ss_ff <= ss_in; sc_ff <= sc_in; sh_ff <= sh_in;
      end
   end

   a_master_off_clears: assert property (@(posedge clock) disable iff (reset)
      (wr && offs == scccu_pkg::R_MASTER && !write_data[7]) |=> (en_ff == 4'd0))
      else $error("enables survive master off");
   a_length_expiry: assert property (@(posedge clock) disable iff (reset)
      (la_ff[0] && lc_ff[0] >= 9'd64 && !wr) |=> !en_ff[0])
      else $error("square1 enabled past length expiry");
   a_tick_master: assert property (@(posedge clock) disable iff (reset)
      (strobe.env || strobe.sweep || strobe.len) |-> master_ff)
      else $error("frame step while master off");

endmodule

// File: rtl/sound_chip_channel_control_unit.sv
// top level of the sound chip channel control unit
// depends on scccu_pkg, scccu_frame_divider and scccu_channel_core
`timescale 1ns / 1ps

// Each request (bus write, bus read or sample tick) is accepted and its
// response lands in an output register the next cycle; a new request can be taken
// every cycle while the response register is empty or being drained. The response
// carries the read byte plus a snapshot of enables, envelope volumes and the
// channel one frequency after the request has been applied. The window
// 0xff10..0xff3f is decoded; reads elsewhere return 0xff. Register file bytes are
// read at the accepting edge into a register beside the response register, and a
// flag per byte makes bytes that were never written read as zero.
module sound_chip_channel_control_unit #(
   parameter int ENVELOPE_TICKS = scccu_pkg::ENVELOPE_TICKS_DEF,
   parameter int SWEEP_TICKS    = scccu_pkg::SWEEP_TICKS_DEF,
   parameter int LENGTH_TICKS   = scccu_pkg::LENGTH_TICKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // bus_address[15:0], write_data[23:16]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // read_data[7:0], channels_on[11:8], square1_volume[15:12],
                                    // square2_volume[19:16], noise_volume[23:20],
                                    // square1_frequency[34:24], zero fill[39:35]
);

   logic                  take, tick;
   scccu_pkg::strobe_type strobe;
   scccu_pkg::result_type result;
   logic                  valid_ff;
   scccu_pkg::result_type data_ff;
   logic [7:0]            mem_data;

   assign req_tready = !valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   scccu_frame_divider #(
      .ENVELOPE_TICKS(ENVELOPE_TICKS),
      .SWEEP_TICKS(SWEEP_TICKS),
      .LENGTH_TICKS(LENGTH_TICKS)
   ) u_div (
      .clock(clock), .reset(reset), .tick(tick), .strobe(strobe)
   );

   scccu_channel_core u_core (
      .clock(clock), .reset(reset), .valid(take),
      .cmd(scccu_pkg::cmd_type'(req_tuser)),
      .bus_address(req_tdata[15:0]), .write_data(req_tdata[23:16]),
      .strobe(strobe), .tick(tick), .result(result), .mem_data(mem_data)
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (take) valid_ff <= 1'b1;
      else if (rsp_tready) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (take) data_ff <= result;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, data_ff.square1_frequency, data_ff.noise_volume,
                        data_ff.square2_volume, data_ff.square1_volume,
                        data_ff.channels_on, data_ff.read_data | mem_data};

endmodule

// File: test/sound_chip_channel_control_unit_tb.sv
// testbench for the sound chip channel control unit
// predicts every response from its own model of the registers, envelopes, sweep and lengths
// depends on scccu_pkg and the rtl of sound_chip_channel_control_unit
`timescale 1ns / 1ps

module sound_chip_channel_control_unit_tb;

   typedef struct {
      logic [7:0]  read_data;
      logic [3:0]  channels_on;
      logic [3:0]  square1_volume;
      logic [3:0]  square2_volume;
      logic [3:0]  noise_volume;
      logic [10:0] square1_frequency;
   } chip_status_type;

   int error_count = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   class apu_scoreboard;
      logic [7:0]  regs [48];
      logic [3:0]  enables;
      logic        master;
      logic [3:0]  env_start [3];
      logic        env_up [3];
      logic [2:0]  env_period [3];
      logic [2:0]  env_count [3];
      logic [3:0]  volume [3];
      logic [8:0]  len_count [4];
      logic        len_on [4];
      logic [10:0] freq [3];
      logic [2:0]  sw_period, sw_shift, sw_count;
      logic        sw_down;
      logic [10:0] sw_shadow;
      int          frame [3];
      chip_status_type pending [$];

      function new();
         foreach (regs[i]) regs[i] = 0;
         for (int i = 0; i < 3; i++) begin
            env_start[i] = 0; env_up[i] = 0; env_period[i] = 0; env_count[i] = 0;
            volume[i] = 0; freq[i] = 0; frame[i] = 0;
         end
         for (int i = 0; i < 4; i++) begin
            len_count[i] = 0; len_on[i] = 0;
         end
         enables = 0; master = 0;
         sw_period = 0; sw_shift = 0; sw_count = 0; sw_down = 0; sw_shadow = 0;
      endfunction

      function int len_max(int c);
         return (c == 2) ? 256 : 64;
      endfunction

      function void set_envelope(int e, int b, logic [7:0] v);
         env_start[e] = v[7:4];
         env_up[e] = v[3];
         env_period[e] = v[2:0];
         if (v[7:3] == 0) enables[b] = 1'b0;
      endfunction

      function void trigger_envelope(int e, int b, logic dac_on);
         if (dac_on) enables[b] = 1'b1;
         volume[e] = env_start[e];
         env_count[e] = env_period[e];
      endfunction

      function void restart_length(int c);
         if (len_count[c] >= len_max(c)) len_count[c] = 0;
      endfunction

      function void advance_envelope(int e);
         if (env_period[e] == 0) return;
         if (env_count[e] > 0) env_count[e]--;
         if (env_count[e] == 0) begin
            env_count[e] = env_period[e];
            if (env_up[e]) begin
               if (volume[e] < 15) volume[e]++;
            end else if (volume[e] > 0) begin
               volume[e]--;
            end
         end
      endfunction

      function void advance_sweep();
         int delta, nxt;
         if (sw_period == 0) return;
         if (sw_count > 0) sw_count--;
         if (sw_count != 0) return;
         sw_count = sw_period;
         if (sw_shift == 0) return;
         delta = int'(sw_shadow) >> sw_shift;
         if (sw_down) begin
            nxt = int'(sw_shadow) - delta;
         end else begin
            nxt = int'(sw_shadow) + delta;
            if (nxt > 2047) begin
               enables[0] = 1'b0;
               return;
            end
         end
         sw_shadow = nxt[10:0];
         freq[0] = sw_shadow;
      endfunction

      function void advance_length(int c);
         if (!len_on[c]) return;
         if (len_count[c] < len_max(c)) len_count[c]++;
         if (len_count[c] >= len_max(c)) enables[c] = 1'b0;
      endfunction

      function void bus_write(logic [15:0] addr, logic [7:0] v);
         logic [5:0] off;
         if (addr < scccu_pkg::WIN_LO || addr > scccu_pkg::WIN_HI) return;
         off = 6'(addr - scccu_pkg::WIN_LO);
         regs[off] = v;
         case (off)
            scccu_pkg::R_SWEEP: begin
               sw_period = v[6:4]; sw_down = v[3]; sw_shift = v[2:0];
            end
            scccu_pkg::R_LEN0: len_count[0] = {3'd0, v[5:0]};
            scccu_pkg::R_ENV0: set_envelope(0, 0, v);
            scccu_pkg::R_FLO0: freq[0][7:0] = v;
            scccu_pkg::R_FHI0: begin
               freq[0][10:8] = v[2:0]; len_on[0] = v[6];
               if (v[7]) begin
                  trigger_envelope(0, 0, regs[scccu_pkg::R_ENV0][7:3] != 0);
                  sw_shadow = freq[0];
                  sw_count = sw_period;
                  restart_length(0);
               end
            end
            scccu_pkg::R_LEN1: len_count[1] = {3'd0, v[5:0]};
            scccu_pkg::R_ENV1: set_envelope(1, 1, v);
            scccu_pkg::R_FLO1: freq[1][7:0] = v;
            scccu_pkg::R_FHI1: begin
               freq[1][10:8] = v[2:0]; len_on[1] = v[6];
               if (v[7]) begin
                  trigger_envelope(1, 1, regs[scccu_pkg::R_ENV1][7:3] != 0);
                  restart_length(1);
               end
            end
            scccu_pkg::R_WDAC: if (!v[7]) enables[2] = 1'b0;
            scccu_pkg::R_LEN2: len_count[2] = {1'b0, v};
            scccu_pkg::R_FLO2: freq[2][7:0] = v;
            scccu_pkg::R_FHI2: begin
               freq[2][10:8] = v[2:0]; len_on[2] = v[6];
               if (v[7]) begin
                  if (regs[scccu_pkg::R_WDAC][7]) enables[2] = 1'b1;
                  restart_length(2);
               end
            end
            scccu_pkg::R_LEN3: len_count[3] = {3'd0, v[5:0]};
            scccu_pkg::R_ENV3: set_envelope(2, 3, v);
            scccu_pkg::R_CTRL3: begin
               len_on[3] = v[6];
               if (v[7]) begin
                  trigger_envelope(2, 3, regs[scccu_pkg::R_ENV3][7:3] != 0);
                  restart_length(3);
               end
            end
            scccu_pkg::R_MASTER: begin
               master = v[7];
               if (!master) enables = 0;
            end
            default: ;
         endcase
      endfunction

      function logic [7:0] bus_read(logic [15:0] addr);
         if (addr < scccu_pkg::WIN_LO || addr > scccu_pkg::WIN_HI) return 8'hff;
         if (addr == scccu_pkg::STATUS_ADDR) return {master, 3'b111, enables};
         return regs[6'(addr - scccu_pkg::WIN_LO)];
      endfunction

      function void sample_tick();
         if (!master) return;
         frame[0]++;
         if (frame[0] >= scccu_pkg::ENVELOPE_TICKS_DEF) begin
            frame[0] = 0;
            for (int e = 0; e < 3; e++) advance_envelope(e);
         end
         frame[1]++;
         if (frame[1] >= scccu_pkg::SWEEP_TICKS_DEF) begin
            frame[1] = 0;
            advance_sweep();
         end
         frame[2]++;
         if (frame[2] >= scccu_pkg::LENGTH_TICKS_DEF) begin
            frame[2] = 0;
            for (int c = 0; c < 4; c++) advance_length(c);
         end
      endfunction

      function void note_request(scccu_pkg::cmd_type cmd, logic [15:0] addr,
                                 logic [7:0] data);
         chip_status_type s;
         s.read_data = 0;
         case (cmd)
            scccu_pkg::CMD_WRITE: bus_write(addr, data);
            scccu_pkg::CMD_READ:  s.read_data = bus_read(addr);
            scccu_pkg::CMD_TICK:  sample_tick();
            default: ;
         endcase
         s.channels_on = enables;
         s.square1_volume = volume[0];
         s.square2_volume = volume[1];
         s.noise_volume = volume[2];
         s.square1_frequency = freq[0];
         pending.push_back(s);
      endfunction

      task check_response(logic [39:0] d);
         chip_status_type w;
         if (pending.size() == 0) begin
            report("unexpected transfer", d[31:0], 0);
            return;
         end
         w = pending.pop_front();
         if (d[7:0] != w.read_data) report("read_data", d[7:0], w.read_data);
         if (d[11:8] != w.channels_on) report("channels_on", d[11:8], w.channels_on);
         if (d[15:12] != w.square1_volume) report("square1_volume", d[15:12], w.square1_volume);
         if (d[19:16] != w.square2_volume) report("square2_volume", d[19:16], w.square2_volume);
         if (d[23:20] != w.noise_volume) report("noise_volume", d[23:20], w.noise_volume);
         if (d[34:24] != w.square1_frequency)
            report("square1_frequency", d[34:24], w.square1_frequency);
         if (d[39:35] != 0) report("zero fill", d[39:35], 0);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = 0;
   logic [1:0]  req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;

   apu_scoreboard board = new();
   bit  calm_phase = 0;     // no idling on either side
   bit  hold_off = 0;       // receiver stalls for a long stretch
   bit  stim_done = 0;
   int  quiet_cycles = 0;

   always #5 clock = ~clock;

   sound_chip_channel_control_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // one request transfer, with a random idle gap before it
   task automatic send_request(input scccu_pkg::cmd_type cmd, input logic [15:0] addr,
                               input logic [7:0] data);
      while (!calm_phase && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, addr, data);
   endtask

   task automatic write_reg(input logic [5:0] off, input logic [7:0] v);
      send_request(scccu_pkg::CMD_WRITE, scccu_pkg::WIN_LO + 16'(off), v);
   endtask

   task automatic tick_burst(input int n);
      for (int i = 0; i < n; i++)
         send_request(scccu_pkg::CMD_TICK, 16'($urandom), 8'($urandom));
   endtask

   function automatic logic [15:0] window_addr();
      return scccu_pkg::WIN_LO + 16'($urandom_range(47));
   endfunction

   // writes that set up and trigger a channel with random content
   task automatic random_trigger();
      case ($urandom_range(3))
         0: begin
            write_reg(scccu_pkg::R_SWEEP, 8'($urandom));
            write_reg(scccu_pkg::R_ENV0, 8'($urandom) | 8'h08);
            write_reg(scccu_pkg::R_LEN0, 8'($urandom));
            write_reg(scccu_pkg::R_FLO0, 8'($urandom));
            write_reg(scccu_pkg::R_FHI0, 8'($urandom) | 8'h80);
         end
         1: begin
            write_reg(scccu_pkg::R_ENV1, 8'($urandom));
            write_reg(scccu_pkg::R_LEN1, 8'($urandom));
            write_reg(scccu_pkg::R_FHI1, 8'($urandom) | 8'h80);
         end
         2: begin
            write_reg(scccu_pkg::R_WDAC, 8'($urandom));
            write_reg(scccu_pkg::R_LEN2, 8'($urandom_range(255, 200)));
            write_reg(scccu_pkg::R_FLO2, 8'($urandom));
            write_reg(scccu_pkg::R_FHI2, 8'($urandom) | 8'h80);
         end
         default: begin
            write_reg(scccu_pkg::R_ENV3, 8'($urandom));
            write_reg(scccu_pkg::R_LEN3, 8'($urandom));
            write_reg(scccu_pkg::R_CTRL3, 8'($urandom) | 8'h80);
         end
      endcase
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) tick_burst(1);
      else if (pick < 50)
         send_request(scccu_pkg::CMD_READ, window_addr(), 8'($urandom));
      else if (pick < 55)
         send_request(scccu_pkg::CMD_READ, 16'($urandom), 8'($urandom));
      else if (pick < 70)
         send_request(scccu_pkg::CMD_WRITE, window_addr(), 8'($urandom));
      else if (pick < 73)
         send_request(scccu_pkg::CMD_WRITE, 16'($urandom), 8'($urandom));
      else if (pick < 75)
         send_request(scccu_pkg::CMD_NONE, 16'($urandom), 8'($urandom));
      else if (pick < 77) write_reg(scccu_pkg::R_MASTER, 8'($urandom) | 8'h80);
      else if (pick < 78) write_reg(scccu_pkg::R_MASTER, 8'($urandom) & 8'h7f);
      else if (pick < 88) random_trigger();
      else tick_burst($urandom_range(5, 20));
   endtask

   // receiver with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         rsp_tready <= !hold_off && (calm_phase || $urandom_range(99) >= 23);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: status and reads before master on, ticks ignored while off
      send_request(scccu_pkg::CMD_READ, scccu_pkg::STATUS_ADDR, 8'h00);
      send_request(scccu_pkg::CMD_READ, 16'h0000, 8'hff);
      send_request(scccu_pkg::CMD_READ, 16'hffff, 8'h00);
      send_request(scccu_pkg::CMD_TICK, 16'h0000, 8'h00);
      send_request(scccu_pkg::CMD_NONE, 16'hffff, 8'hff);
      send_request(scccu_pkg::CMD_WRITE, 16'hff0f, 8'hff);
      send_request(scccu_pkg::CMD_WRITE, 16'hff40, 8'hff);
      write_reg(6'h2f, 8'hff);
      send_request(scccu_pkg::CMD_READ, scccu_pkg::WIN_HI, 8'h00);
      write_reg(scccu_pkg::R_MASTER, 8'hff);
      send_request(scccu_pkg::CMD_READ, scccu_pkg::STATUS_ADDR, 8'h00);
      // channel one: upward sweep to overflow, rising envelope, dac off trigger; then wave and noise triggers
      write_reg(scccu_pkg::R_ENV0, 8'h07);
      write_reg(scccu_pkg::R_FHI0, 8'h80);
      write_reg(scccu_pkg::R_SWEEP, 8'h11);
      write_reg(scccu_pkg::R_ENV0, 8'h09);
      write_reg(scccu_pkg::R_FLO0, 8'hff);
      write_reg(scccu_pkg::R_FHI0, 8'hc6);
      write_reg(scccu_pkg::R_WDAC, 8'h80);
      write_reg(scccu_pkg::R_LEN2, 8'hfe);
      write_reg(scccu_pkg::R_FHI2, 8'hc0 | 8'h80);
      write_reg(scccu_pkg::R_ENV3, 8'hf7);
      write_reg(scccu_pkg::R_LEN3, 8'h3f);
      write_reg(scccu_pkg::R_CTRL3, 8'hc0);
      tick_burst(180);
      write_reg(scccu_pkg::R_WDAC, 8'h00);
      write_reg(scccu_pkg::R_MASTER, 8'h00);
      // random part, with a calm stretch and a long receiver hold-off
      for (int n = 0; n < 150; n++) begin
         calm_phase = (n >= 50 && n < 100);
         if (n == 110) begin
            fork
               begin
                  hold_off = 1;
                  repeat (60) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         random_item();
      end
      req_tvalid <= 1'b0;
      stim_done = 1;
   end

   // watchdog and end of run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 2000) begin
         $display("FAIL sound_chip_channel_control_unit");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0 && !rsp_tvalid) begin
         $display("PASS sound_chip_channel_control_unit");
      end else begin
         $display("FAIL sound_chip_channel_control_unit");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/scccu_pkg.sv
rtl/scccu_frame_divider.sv
rtl/scccu_channel_core.sv
rtl/sound_chip_channel_control_unit.sv
test/sound_chip_channel_control_unit_tb.sv
